/* design/vt4_pkg.sv */
`default_nettype none

package vt4_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	// four products of magnitude up to 2^62 need two guard bits
	localparam int ACC_W     = PROD_W + 2;
	localparam int NUM_COLS  = 4;
	localparam int NUM_REGS  = 2 * NUM_COLS;
	localparam int REG_W     = 64;
	localparam int IDX_W     = $clog2(NUM_REGS);

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'd1 << FRAC_BITS);
	localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'd1 << (FRAC_BITS + DATA_W));

	typedef logic [3:0][DATA_W-1:0] vec_t;
	typedef logic [3:0][ACC_W-1:0]  acc_t;

endpackage

`default_nettype wire

/* design/vt4_cell.sv */
`default_nettype none

// One matrix column: multiplies its input component by the column's four
// entries and adds the products onto the partial sums from the previous cell.
module vt4_cell import vt4_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire vec_t              col,
	input  wire logic [DATA_W-1:0] comp,
	input  wire logic              up_valid,
	output logic                   up_ready,
	input  wire vec_t              up_vec,
	input  wire acc_t              up_acc,
	output logic                   dn_valid,
	input  wire logic              dn_ready,
	output vec_t                   dn_vec,
	output acc_t                   dn_acc
);

	logic                          valid_s1;
	logic                          valid_s2;
	vec_t                          vec_s1;
	vec_t                          vec_s2;
	acc_t                          acc_s1;
	acc_t                          acc_s2;
	logic [3:0][PROD_W-1:0]        prod_s1;
	logic                          ld1;
	logic                          ld2;

	assign ld2      = !valid_s2 || dn_ready;
	assign ld1      = !valid_s1 || ld2;
	assign up_ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ld1) valid_s1 <= up_valid;
			if (ld2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && up_valid) begin
			vec_s1 <= up_vec;
			acc_s1 <= up_acc;
			for (int r = 0; r < 4; r++) begin
				prod_s1[r] <= PROD_W'($signed(col[r]) * $signed(comp));
			end
		end
		if (ld2 && valid_s1) begin
			vec_s2 <= vec_s1;
			for (int r = 0; r < 4; r++) begin
				acc_s2[r] <= acc_s1[r] + {{(ACC_W-PROD_W){prod_s1[r][PROD_W-1]}}, prod_s1[r]};
			end
		end
	end

	assign dn_valid = valid_s2;
	assign dn_vec   = vec_s2;
	assign dn_acc   = acc_s2;

endmodule

`default_nettype wire

/* design/vt4_sat.sv */
`default_nettype none

// Output stage: drop the fraction bits, clamp to 32 bits, hold the result.
module vt4_sat import vt4_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              up_valid,
	output logic                   up_ready,
	input  wire acc_t              up_acc,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output vec_t                   res,
	output logic                   res_sat
);

	logic                          valid_q;
	vec_t                          res_q;
	logic                          sat_q;
	vec_t                          res_d;
	logic [3:0]                    clamp;
	logic [ACC_W-1:0]              sh;
	logic                          ld;

	assign ld       = !valid_q || !out_stall;
	assign up_ready = ld;

	always_comb begin
		res_d = '0;
		clamp = '0;
		sh    = '0;
		for (int r = 0; r < 4; r++) begin
			sh = ACC_W'($signed(up_acc[r]) >>> FRAC_BITS);
			// in range when every bit above the sign position matches it
			if (sh[ACC_W-1:DATA_W-1] == '0 || sh[ACC_W-1:DATA_W-1] == '1) begin
				res_d[r] = sh[DATA_W-1:0];
			end else begin
				clamp[r] = 1'b1;
				res_d[r] = sh[ACC_W-1] ? SAT_MIN : SAT_MAX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld && up_valid) begin
			res_q <= res_d;
			sat_q <= |clamp;
		end
	end

	assign out_valid = valid_q;
	assign res       = res_q;
	assign res_sat   = sat_q;

endmodule

`default_nettype wire

/* design/vertex_transform_4x4_unit.sv */
`default_nettype none

// Channel  | Direction | Handshake           | Payload
// input    | in        | in_valid / in_stall | in_x, in_y, in_z, in_w
// output   | out       | out_valid/out_stall | out_x, out_y, out_z, out_w, out_saturated
// config   | in        | cfg_write           | cfg_index, cfg_data
//
// One vertex per cycle sustained while out_stall is low; a vertex reaches out_valid
// after the chain of four column cells, two stages each (multiply, then
// accumulate), and then the clamp/output register.
// Reset clears all valid flags and loads the identity matrix.
// A stall holds the output; upstream stages keep filling until each is full.
module vertex_transform_4x4_unit import vt4_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [REG_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [DATA_W-1:0] in_x,
	input  wire logic [DATA_W-1:0] in_y,
	input  wire logic [DATA_W-1:0] in_z,
	input  wire logic [DATA_W-1:0] in_w,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DATA_W-1:0]      out_x,
	output logic [DATA_W-1:0]      out_y,
	output logic [DATA_W-1:0]      out_z,
	output logic [DATA_W-1:0]      out_w,
	output logic                   out_saturated
);

	logic [NUM_REGS-1:0][REG_W-1:0] mat_q;
	logic [NUM_COLS:0]              ch_valid;
	logic [NUM_COLS:0]              ch_ready;
	vec_t [NUM_COLS:0]              ch_vec;
	acc_t [NUM_COLS:0]              ch_acc;
	vec_t                           res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= ONE_LO;
			mat_q[1] <= '0;
			mat_q[2] <= ONE_HI;
			mat_q[3] <= '0;
			mat_q[4] <= '0;
			mat_q[5] <= ONE_LO;
			mat_q[6] <= '0;
			mat_q[7] <= ONE_HI;
		end else if (cfg_write) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	assign ch_valid[0] = in_valid;
	assign ch_vec[0]   = {in_w, in_z, in_y, in_x};
	assign ch_acc[0]   = '0;
	assign in_stall    = !ch_ready[0];

	for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
		vec_t col;

		assign col = {mat_q[2*c+1][REG_W-1:DATA_W], mat_q[2*c+1][DATA_W-1:0],
		              mat_q[2*c][REG_W-1:DATA_W], mat_q[2*c][DATA_W-1:0]};

		vt4_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.col      (col),
			.comp     (ch_vec[c][c]),
			.up_valid (ch_valid[c]),
			.up_ready (ch_ready[c]),
			.up_vec   (ch_vec[c]),
			.up_acc   (ch_acc[c]),
			.dn_valid (ch_valid[c+1]),
			.dn_ready (ch_ready[c+1]),
			.dn_vec   (ch_vec[c+1]),
			.dn_acc   (ch_acc[c+1])
		);
	end

	vt4_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (ch_valid[NUM_COLS]),
		.up_ready  (ch_ready[NUM_COLS]),
		.up_acc    (ch_acc[NUM_COLS]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.res_sat   (out_saturated)
	);

	assign out_x = res[0];
	assign out_y = res[1];
	assign out_z = res[2];
	assign out_w = res[3];

endmodule

`default_nettype wire

/* design/vt4_checker.sv */
`default_nettype none

module vt4_checker import vt4_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [DATA_W-1:0] out_x,
	input wire logic [DATA_W-1:0] out_y,
	input wire logic [DATA_W-1:0] out_z,
	input wire logic [DATA_W-1:0] out_w,
	input wire logic              out_saturated
);

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(out_w) && $stable(out_saturated))
		else $error("output changed while stalled");

	// a clamp flag needs at least one component at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_saturated |->
			out_x == SAT_MAX || out_x == SAT_MIN || out_y == SAT_MAX || out_y == SAT_MIN ||
			out_z == SAT_MAX || out_z == SAT_MIN || out_w == SAT_MAX || out_w == SAT_MIN)
		else $error("saturation flag without clamped component");

	// with the output stage free the whole chain can move
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || !out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind vertex_transform_4x4_unit vt4_checker u_vt4_checker (.*);

`default_nettype wire
